// ----- src/cpa_pkg.sv -----
// shared types and constants of the chunk pool allocator
package cpa_pkg;

    localparam int REG_POOLS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_0 = 3'd4;

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_MUL,
        S_ALLOC_FIN,
        S_DIV,
        S_FREE_IDX,
        S_FREE_MUL,
        S_FREE_CMP,
        S_FREE_WR,
        S_RESP
    } state_t;

endpackage

// ----- src/cpa_ram.sv -----
// generic single write port ram with registered read
module cpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/chunk_pool_allocator.sv -----
// top level of the chunk pool allocator
// Up to four pools of fixed-size chunks share one usage-bit ram of 32-bit words, one word
// per cycle. Allocate scans a pool's words from the lowest one, one word a cycle, and takes
// the lowest free chunk. A found chunk then goes through S_ALLOC_MUL and S_ALLOC_FIN to
// S_RESP; when no word has a free bit, the last scanned word goes straight to S_RESP.
// Free divides (address - base) by the chunk size in a radix-2 divider, one quotient bit
// a cycle, then goes through S_FREE_IDX, S_FREE_MUL, S_FREE_CMP and S_FREE_WR to S_RESP,
// leaving for S_RESP early when the index is out of range. A request to a disabled pool,
// or a free below the pool base, goes straight from S_IDLE to S_RESP.
// One request is in work at a time; the result waits in an output register. A per-pool
// fill mark tells how many low words were ever written, so reset and a chunk size write
// clear a pool at once without a clearing pass.
module chunk_pool_allocator #(
    parameter int POOLS        = 4,
    parameter int MAX_CHUNKS   = 1024,
    parameter int REGION_BYTES = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [1:0]                         pool_sel,
    input  logic [cpa_pkg::ADDR_W-1:0]         chunk_addr,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cpa_pkg::ADDR_W-1:0]         granted_addr,
    output logic [1:0]                         status
);

    localparam int NWORDS    = (MAX_CHUNKS + cpa_pkg::WORD_W - 1) / cpa_pkg::WORD_W;
    localparam int WB        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PB        = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int IDX_W     = WB + cpa_pkg::WORD_SHIFT;
    localparam int HW_W      = $clog2(NWORDS + 1);
    localparam int PROD_W    = IDX_W + cpa_pkg::SIZE_W + 2;
    localparam int GPROD_W   = IDX_W + cpa_pkg::SIZE_W;
    localparam int LAST_BITS = MAX_CHUNKS - (NWORDS - 1) * cpa_pkg::WORD_W;
    localparam int RAM_AW    = PB + WB;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int SW        = cpa_pkg::SIZE_W;
    localparam int AW        = cpa_pkg::ADDR_W;
    localparam int WW        = cpa_pkg::WORD_W;

    cpa_pkg::state_t state_reg, state_next;

    // configuration registers and per-pool fill marks
    logic [SW-1:0]   size_reg    [cpa_pkg::REG_POOLS];
    logic [AW-1:0]   base_reg    [cpa_pkg::REG_POOLS];
    logic [HW_W-1:0] hiwater_reg [cpa_pkg::REG_POOLS];

    // request and work registers
    logic [1:0]      pool_reg, pool_next;
    logic [WB-1:0]   scan_word_reg, scan_word_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [WW-1:0]   word_data_reg, word_data_next;
    logic [AW-1:0]   dividend_reg, dividend_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [4:0]      div_cnt_reg, div_cnt_next;
    logic [PROD_W-1:0]  cnt_prod_reg, cnt_prod_next;
    logic [GPROD_W-1:0] gr_prod_reg, gr_prod_next;
    logic [AW-1:0]   res_addr_reg, res_addr_next;
    cpa_pkg::status_t res_status_reg, res_status_next;
    logic            hw_bump;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [AW-1:0]   granted_addr_reg, granted_addr_next;
    cpa_pkg::status_t status_reg, status_next;

    // ram ports
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WW-1:0]     ram_rdata;

    // shared decode
    logic            in_fire;
    logic            acc_disabled;
    logic            acc_below;
    logic [SW-1:0]   size_cur;
    logic [AW-1:0]   base_cur;
    logic [HW_W-1:0] hw_cur;
    logic [WW-1:0]   scan_data;
    logic            scan_found;
    logic [4:0]      scan_bit;
    logic            scan_last;
    logic [WB-1:0]   idx_word;
    logic [4:0]      idx_bit;
    logic [SW:0]     div_trial;
    logic            div_ge;
    logic            q_big;
    logic            cnt_over;

    cpa_ram #(
        .WIDTH (WW),
        .DEPTH (RAM_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_fire      = in_valid && in_ready;
    assign acc_disabled = ({1'b0, pool_sel} >= 3'(POOLS)) || (size_reg[pool_sel] == '0);
    assign acc_below    = chunk_addr < base_reg[pool_sel];
    assign size_cur     = size_reg[pool_reg];
    assign base_cur     = base_reg[pool_reg];
    assign hw_cur       = hiwater_reg[pool_reg];
    assign scan_last    = scan_word_reg == WB'(NWORDS - 1);
    assign idx_word     = idx_reg[IDX_W-1:cpa_pkg::WORD_SHIFT];
    assign idx_bit      = idx_reg[cpa_pkg::WORD_SHIFT-1:0];
    assign div_trial    = {rem_reg, dividend_reg[AW-1]};
    assign div_ge       = div_trial >= {1'b0, size_cur};
    assign q_big        = dividend_reg >= AW'(MAX_CHUNKS);
    assign cnt_over     = cnt_prod_reg > PROD_W'(REGION_BYTES);

    // scanned word: unwritten words read as free, bits past the last chunk as used
    always_comb
    begin
        scan_data = (HW_W'(scan_word_reg) < hw_cur) ? ram_rdata : '0;
        for (int b = 0; b < WW; b++)
        begin
            if (scan_last && (b >= LAST_BITS))
            begin
                scan_data[b] = 1'b1;
            end
        end
    end

    // lowest free bit of the scanned word
    always_comb
    begin
        scan_found = 1'b0;
        scan_bit   = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (!scan_data[b])
            begin
                scan_found = 1'b1;
                scan_bit   = 5'(b);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (acc_disabled)
                        state_next = cpa_pkg::S_RESP;
                    else if (op == cpa_pkg::OP_ALLOC)
                        state_next = cpa_pkg::S_SCAN_RD;
                    else if (acc_below)
                        state_next = cpa_pkg::S_RESP;
                    else
                        state_next = cpa_pkg::S_DIV;
                end
            end
            cpa_pkg::S_SCAN_RD:
                state_next = cpa_pkg::S_SCAN_CHK;
            cpa_pkg::S_SCAN_CHK:
            begin
                if (scan_found)
                    state_next = cpa_pkg::S_ALLOC_MUL;
                else if (scan_last)
                    state_next = cpa_pkg::S_RESP;
            end
            cpa_pkg::S_ALLOC_MUL:
                state_next = cpa_pkg::S_ALLOC_FIN;
            cpa_pkg::S_ALLOC_FIN:
                state_next = cpa_pkg::S_RESP;
            cpa_pkg::S_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                    state_next = cpa_pkg::S_FREE_IDX;
            end
            cpa_pkg::S_FREE_IDX:
                state_next = q_big ? cpa_pkg::S_RESP : cpa_pkg::S_FREE_MUL;
            cpa_pkg::S_FREE_MUL:
                state_next = cpa_pkg::S_FREE_CMP;
            cpa_pkg::S_FREE_CMP:
            begin
                if (!cnt_over && (HW_W'(idx_word) < hw_cur))
                    state_next = cpa_pkg::S_FREE_WR;
                else
                    state_next = cpa_pkg::S_RESP;
            end
            cpa_pkg::S_FREE_WR:
                state_next = cpa_pkg::S_RESP;
            cpa_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = cpa_pkg::S_IDLE;
            end
            default:
                state_next = cpa_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        in_ready          = state_reg == cpa_pkg::S_IDLE;
        pool_next         = pool_reg;
        scan_word_next    = scan_word_reg;
        idx_next          = idx_reg;
        word_data_next    = word_data_reg;
        dividend_next     = dividend_reg;
        rem_next          = rem_reg;
        div_cnt_next      = div_cnt_reg;
        cnt_prod_next     = cnt_prod_reg;
        gr_prod_next      = gr_prod_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        hw_bump           = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = {pool_reg[PB-1:0], idx_word};
        ram_wdata         = word_data_reg;
        ram_raddr         = {pool_reg[PB-1:0], scan_word_reg};
        out_valid_next    = out_valid_reg && !out_ready;
        granted_addr_next = granted_addr_reg;
        status_next       = status_reg;

        case (state_reg)
            cpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    pool_next       = pool_sel;
                    scan_word_next  = '0;
                    dividend_next   = chunk_addr - base_reg[pool_sel];
                    rem_next        = '0;
                    div_cnt_next    = '0;
                    res_addr_next   = '0;
                    res_status_next = cpa_pkg::ST_OK;
                    if (acc_disabled)
                        res_status_next = cpa_pkg::ST_DISABLED;
                    else if ((op == cpa_pkg::OP_FREE) && acc_below)
                        res_status_next = cpa_pkg::ST_RANGE;
                end
            end
            cpa_pkg::S_SCAN_CHK:
            begin
                // check this word while the next one is read
                ram_raddr = {pool_reg[PB-1:0], scan_word_reg + WB'(1)};
                if (scan_found)
                begin
                    idx_next       = {scan_word_reg, scan_bit};
                    word_data_next = scan_data;
                end
                else if (scan_last)
                begin
                    res_status_next = cpa_pkg::ST_FULL;
                end
                else
                begin
                    scan_word_next = scan_word_reg + WB'(1);
                end
            end
            cpa_pkg::S_ALLOC_MUL, cpa_pkg::S_FREE_MUL:
            begin
                cnt_prod_next = (PROD_W'(idx_reg) + PROD_W'(1)) * PROD_W'(size_cur)
                              + (PROD_W'(idx_reg) + PROD_W'(1));
                gr_prod_next  = GPROD_W'(idx_reg) * GPROD_W'(size_cur);
            end
            cpa_pkg::S_ALLOC_FIN:
            begin
                if (cnt_over)
                begin
                    res_status_next = cpa_pkg::ST_FULL;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_wdata     = word_data_reg | (WW'(1) << idx_bit);
                    res_addr_next = base_cur + AW'(gr_prod_reg);
                    hw_bump       = HW_W'(idx_word) == hw_cur;
                end
            end
            cpa_pkg::S_DIV:
            begin
                // one quotient bit a cycle, shifted into the dividend
                rem_next      = div_ge ? SW'(div_trial - {1'b0, size_cur}) : SW'(div_trial);
                dividend_next = {dividend_reg[AW-2:0], div_ge};
                div_cnt_next  = div_cnt_reg + 5'd1;
            end
            cpa_pkg::S_FREE_IDX:
            begin
                idx_next = IDX_W'(dividend_reg);
                if (q_big)
                    res_status_next = cpa_pkg::ST_RANGE;
            end
            cpa_pkg::S_FREE_CMP:
            begin
                ram_raddr = {pool_reg[PB-1:0], idx_word};
                if (cnt_over)
                    res_status_next = cpa_pkg::ST_RANGE;
            end
            cpa_pkg::S_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WW'(1) << idx_bit);
            end
            cpa_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    granted_addr_next = res_addr_reg;
                    status_next       = res_status_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers, configuration and fill marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < cpa_pkg::REG_POOLS; p++)
            begin
                size_reg[p]    <= '0;
                base_reg[p]    <= '0;
                hiwater_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (hw_bump)
            begin
                hiwater_reg[pool_reg] <= hw_cur + HW_W'(1);
            end
            if (cfg_we)
            begin
                if (cfg_index <= cpa_pkg::REG_SIZE_3)
                begin
                    size_reg[cfg_index[1:0]]    <= SW'(cfg_data);
                    hiwater_reg[cfg_index[1:0]] <= '0;
                end
                else if (cfg_index >= cpa_pkg::REG_BASE_0)
                begin
                    base_reg[cfg_index[1:0]] <= AW'(cfg_data);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pool_reg         <= pool_next;
        scan_word_reg    <= scan_word_next;
        idx_reg          <= idx_next;
        word_data_reg    <= word_data_next;
        dividend_reg     <= dividend_next;
        rem_reg          <= rem_next;
        div_cnt_reg      <= div_cnt_next;
        cnt_prod_reg     <= cnt_prod_next;
        gr_prod_reg      <= gr_prod_next;
        res_addr_reg     <= res_addr_next;
        res_status_reg   <= res_status_next;
        granted_addr_reg <= granted_addr_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign granted_addr = granted_addr_reg;
    assign status       = status_reg;

endmodule

// ----- dv/tb_chunk_pool_allocator.sv -----
// testbench for the chunk pool allocator: directed and random requests checked by a predictor
`timescale 1ns / 1ps

module tb_chunk_pool_allocator;

    localparam int NPOOL      = 4;
    localparam int CHUNK_CAP  = 1024;
    localparam int REGION     = 65536;
    localparam int DRAIN_CYC  = 60;
    localparam int STALL_LIM  = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [1:0]  pool_sel;
    logic [31:0] chunk_addr;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] granted_addr;
    logic [1:0]  status;

    // predictor state
    logic [15:0] pool_size [NPOOL];
    logic [31:0] pool_base [NPOOL];
    bit          chunk_used [NPOOL][CHUNK_CAP];

    typedef struct packed {
        logic [31:0]      addr;
        cpa_pkg::status_t st;
    } grant_t;

    grant_t grant_q[$];
    int     fail_cnt = 0;
    int     idle_cycles = 0;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_recv;
    bit     done;

    chunk_pool_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .pool_sel     (pool_sel),
        .chunk_addr   (chunk_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_addr (granted_addr),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int chunk_count(input logic [15:0] sz);
        int n;
        n = REGION / (int'(sz) + 1);
        if (n > CHUNK_CAP)
            n = CHUNK_CAP;
        return n;
    endfunction

    // compute the response of one request and update the usage marks
    function automatic grant_t predict_grant(input logic o, input logic [1:0] sel,
                                             input logic [31:0] a);
        grant_t g;
        int     cnt;
        logic [31:0] idx;
        g.addr = '0;
        g.st   = cpa_pkg::ST_OK;
        if (pool_size[sel] == 16'd0)
        begin
            g.st = cpa_pkg::ST_DISABLED;
            return g;
        end
        cnt = chunk_count(pool_size[sel]);
        if (o == cpa_pkg::OP_ALLOC)
        begin
            g.st = cpa_pkg::ST_FULL;
            for (int i = 0; i < cnt; i++)
            begin
                if (!chunk_used[sel][i])
                begin
                    chunk_used[sel][i] = 1'b1;
                    g.addr = pool_base[sel] + 32'(i) * 32'(pool_size[sel]);
                    g.st   = cpa_pkg::ST_OK;
                    break;
                end
            end
        end
        else if (a < pool_base[sel])
            g.st = cpa_pkg::ST_RANGE;
        else
        begin
            idx = (a - pool_base[sel]) / 32'(pool_size[sel]);
            if (idx >= 32'(cnt))
                g.st = cpa_pkg::ST_RANGE;
            else
                chunk_used[sel][idx] = 1'b0;
        end
        return g;
    endfunction

    // register write, only while idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < cpa_pkg::REG_BASE_0)
        begin
            pool_size[idx[1:0]] = val[15:0];
            for (int i = 0; i < CHUNK_CAP; i++)
                chunk_used[idx[1:0]][i] = 1'b0;
        end
        else
            pool_base[idx[1:0]] = val;
    endtask

    task automatic set_pool(input int p, input logic [15:0] sz, input logic [31:0] base);
        write_reg(cpa_pkg::REG_BASE_0 + 3'(p), base);
        write_reg(cpa_pkg::REG_SIZE_0 + 3'(p), {16'd0, sz});
    endtask

    // send one transaction, with random idle before it; valid stays up for a next one
    task automatic send_req(input logic o, input logic [1:0] sel, input logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        pool_sel   <= sel;
        chunk_addr <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        grant_q.push_back(predict_grant(o, sel, a));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_addr_in_pool(input int p);
        int cnt;
        cnt = chunk_count(pool_size[p]);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return pool_base[p] - 32'($urandom_range(1, 64));
            2:       return pool_base[p] + 32'(cnt) * 32'(pool_size[p])
                            + 32'($urandom_range(0, 3));
            default: return pool_base[p] + 32'($urandom_range(0, cnt - 1))
                            * 32'(pool_size[p]) + 32'($urandom_range(0, pool_size[p] - 1));
        endcase
    endfunction

    task automatic rand_req(input int nfree_pct);
        int p;
        p = $urandom_range(3);
        if ($urandom_range(99) < nfree_pct)
            send_req(cpa_pkg::OP_FREE, 2'(p), rand_addr_in_pool(p));
        else
            send_req(cpa_pkg::OP_ALLOC, 2'(p), $urandom);
    endtask

    // receiver with random stalls and an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each response with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected response addr %h status %0d", $time,
                         granted_addr, status);
                fail_cnt++;
            end
            else
            begin
                grant_t g;
                g = grant_q.pop_front();
                if (granted_addr !== g.addr)
                begin
                    $display("%0t: granted_addr expected %h actual %h", $time,
                             g.addr, granted_addr);
                    fail_cnt++;
                end
                if (status !== g.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, g.st, status);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIM)
        begin
            $display("tb_chunk_pool_allocator: errors");
            $finish;
        end
    end

    task automatic test_disabled();
        send_req(cpa_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_req(cpa_pkg::OP_FREE, 2'd3, 32'hFFFF_FFFF);
        wait_drain();
    endtask

    task automatic test_directed();
        set_pool(0, 16'd1, 32'h0000_0000);
        set_pool(1, 16'hFFFF, 32'hFFFF_0000);
        set_pool(2, 16'd64, 32'h1000_0000);
        set_pool(3, 16'd4096, 32'h8000_0000);
        for (int i = 0; i < 17; i++)
            send_req(cpa_pkg::OP_ALLOC, 2'd3, 32'd0);
        send_req(cpa_pkg::OP_ALLOC, 2'd1, 32'd0);
        send_req(cpa_pkg::OP_ALLOC, 2'd1, 32'd0);
        send_req(cpa_pkg::OP_FREE, 2'd1, 32'hFFFF_FFFF);
        send_req(cpa_pkg::OP_FREE, 2'd3, 32'h8000_1FFF);
        send_req(cpa_pkg::OP_FREE, 2'd3, 32'h8000_1FFF);
        send_req(cpa_pkg::OP_FREE, 2'd2, 32'h0FFF_FFFF);
        send_req(cpa_pkg::OP_FREE, 2'd2, 32'h1000_0000 + 32'd64 * 32'd1008);
        send_req(cpa_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_req(cpa_pkg::OP_FREE, 2'd0, 32'd0);
        send_req(cpa_pkg::OP_ALLOC, 2'd3, 32'd0);
        wait_drain();
    endtask

    task automatic test_fill_pool();
        // pool of 1024 chunks filled to the top, then full, then its top chunk freed and taken again
        set_pool(0, 16'd1, 32'($urandom));
        for (int i = 0; i < CHUNK_CAP + 2; i++)
            send_req(cpa_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_req(cpa_pkg::OP_FREE, 2'd0, pool_base[0] + 32'd1023);
        send_req(cpa_pkg::OP_ALLOC, 2'd0, 32'd0);
        wait_drain();
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            rand_req($urandom_range(30, 60));
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                rand_req(40);
        join
        wait_drain();
    endtask

    task automatic reconfig_random();
        for (int p = 0; p < NPOOL; p++)
        begin
            case ($urandom_range(5))
                0:       set_pool(p, 16'd0, $urandom);
                1:       set_pool(p, 16'($urandom_range(1, 65535)), $urandom);
                2:       set_pool(p, 16'($urandom_range(2048, 8192)), $urandom);
                default: set_pool(p, 16'($urandom_range(1, 200)), $urandom);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = cpa_pkg::OP_ALLOC;
        pool_sel = '0;
        chunk_addr = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        done = 1'b0;
        for (int p = 0; p < NPOOL; p++)
        begin
            pool_size[p] = '0;
            pool_base[p] = '0;
            for (int i = 0; i < CHUNK_CAP; i++)
                chunk_used[p][i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled();
        test_directed();
        test_fill_pool();
        reconfig_random();
        test_random(150, 0, 0);
        test_backpressure();
        reconfig_random();
        test_random(100, 80, 0);
        reconfig_random();
        test_random(100, 0, 80);
        reconfig_random();
        test_random(100, 23, 23);
        // pause until all responses are back, then continue
        reconfig_random();
        test_random(150, 0, 0);
        done = 1'b1;

        if (fail_cnt == 0)
            $display("tb_chunk_pool_allocator: clean");
        else
            $display("tb_chunk_pool_allocator: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cpa_pkg.sv
src/cpa_ram.sv
src/chunk_pool_allocator.sv
dv/tb_chunk_pool_allocator.sv
